// ----- sv/qpvt_pkg.sv -----
// Shared types, codes and candidate tables for the quadruple point violation test.
`default_nettype none

package qpvt_pkg;

    // Request opcodes
    localparam logic [1:0] OP_LOAD_POINT = 2'd0;
    localparam logic [1:0] OP_LOAD_FRAC  = 2'd1;
    localparam logic [1:0] OP_CHECK      = 2'd2;

    // Test kinds
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_FACE   = 2'd2;

    localparam logic [2:0] NUM_POINTS = 3'd5;
    localparam logic [2:0] NUM_EDGES  = 3'd6;
    localparam logic [2:0] QUAD_SLOT  = 3'd4;
    localparam logic [1:0] LAST_ROLE  = 2'd2;
    localparam logic [1:0] LAST_COORD = 2'd2;

    // Multiply steps: 0..5 build the normal, 6..11 the plane distance
    localparam logic [3:0] STEP_DIST0 = 4'd6;
    localparam logic [3:0] STEP_LAST  = 4'd11;

    // Point reference: a corner (t holds its index) or the cut point on edge f->t
    typedef struct packed {
        logic       is_edge;
        logic [1:0] f;
        logic [1:0] t;
    } ref_t;

    // Plane refs: [0] base, [1] A, [2] B
    typedef ref_t [2:0] plane_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LD_CORNER,
        DP_EDGE_F,
        DP_EDGE_T,
        DP_EDGE_MUL,
        DP_EDGE_ADD,
        DP_DIFF,
        DP_MUL,
        DP_ACC
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       wr_pt;
        logic       wr_fr;
        logic [2:0] pt_addr;
        logic [2:0] fr_addr;
        logic       fr_hi;
        logic [1:0] role;
        logic [1:0] coord;
        logic [3:0] step;
    } dp_cmd_t;

    function automatic ref_t cr(input logic [1:0] c);
        ref_t r;
        r.is_edge = 1'b0;
        r.f       = 2'd0;
        r.t       = c;
        return r;
    endfunction

    function automatic ref_t er(input logic [1:0] f, input logic [1:0] t);
        ref_t r;
        r.is_edge = 1'b1;
        r.f       = f;
        r.t       = t;
        return r;
    endfunction

    function automatic plane_t mkpl(input ref_t b, input ref_t a, input ref_t c);
        plane_t p;
        p[0] = b;
        p[1] = a;
        p[2] = c;
        return p;
    endfunction

    function automatic plane_t cand_plane(input logic [3:0] cand, input logic [1:0] plane);
        plane_t p;
        p = mkpl(cr(2'd0), cr(2'd0), cr(2'd0));
        unique case ({cand, plane})
            {4'd0, 2'd0}:  p = mkpl(er(2'd0, 2'd1), cr(2'd2), cr(2'd3));
            {4'd0, 2'd1}:  p = mkpl(er(2'd0, 2'd2), cr(2'd3), cr(2'd1));
            {4'd0, 2'd2}:  p = mkpl(er(2'd0, 2'd3), cr(2'd1), cr(2'd2));
            {4'd1, 2'd0}:  p = mkpl(er(2'd1, 2'd0), cr(2'd3), cr(2'd2));
            {4'd1, 2'd1}:  p = mkpl(er(2'd1, 2'd3), cr(2'd2), cr(2'd0));
            {4'd1, 2'd2}:  p = mkpl(er(2'd1, 2'd2), cr(2'd0), cr(2'd3));
            {4'd2, 2'd0}:  p = mkpl(er(2'd2, 2'd0), cr(2'd1), cr(2'd3));
            {4'd2, 2'd1}:  p = mkpl(er(2'd2, 2'd3), cr(2'd0), cr(2'd1));
            {4'd2, 2'd2}:  p = mkpl(er(2'd2, 2'd1), cr(2'd3), cr(2'd0));
            {4'd3, 2'd0}:  p = mkpl(er(2'd3, 2'd0), cr(2'd2), cr(2'd1));
            {4'd3, 2'd1}:  p = mkpl(er(2'd3, 2'd2), cr(2'd1), cr(2'd0));
            {4'd3, 2'd2}:  p = mkpl(er(2'd3, 2'd1), cr(2'd0), cr(2'd2));
            {4'd4, 2'd0}:  p = mkpl(cr(2'd1), er(2'd0, 2'd2), er(2'd0, 2'd3));
            {4'd4, 2'd1}:  p = mkpl(cr(2'd0), er(2'd1, 2'd3), er(2'd1, 2'd2));
            {4'd5, 2'd0}:  p = mkpl(cr(2'd2), er(2'd0, 2'd3), er(2'd0, 2'd1));
            {4'd5, 2'd1}:  p = mkpl(cr(2'd0), er(2'd2, 2'd1), er(2'd2, 2'd3));
            {4'd6, 2'd0}:  p = mkpl(cr(2'd3), er(2'd0, 2'd1), er(2'd0, 2'd2));
            {4'd6, 2'd1}:  p = mkpl(cr(2'd0), er(2'd3, 2'd2), er(2'd3, 2'd1));
            {4'd7, 2'd0}:  p = mkpl(cr(2'd2), er(2'd1, 2'd0), er(2'd1, 2'd3));
            {4'd7, 2'd1}:  p = mkpl(cr(2'd1), er(2'd2, 2'd3), er(2'd2, 2'd0));
            {4'd8, 2'd0}:  p = mkpl(cr(2'd3), er(2'd1, 2'd2), er(2'd1, 2'd0));
            {4'd8, 2'd1}:  p = mkpl(cr(2'd1), er(2'd3, 2'd0), er(2'd3, 2'd2));
            {4'd9, 2'd0}:  p = mkpl(cr(2'd3), er(2'd2, 2'd0), er(2'd2, 2'd1));
            {4'd9, 2'd1}:  p = mkpl(cr(2'd2), er(2'd3, 2'd1), er(2'd3, 2'd0));
            {4'd10, 2'd0}: p = mkpl(cr(2'd0), er(2'd1, 2'd3), er(2'd2, 2'd3));
            {4'd10, 2'd1}: p = mkpl(cr(2'd1), er(2'd2, 2'd3), er(2'd0, 2'd3));
            {4'd10, 2'd2}: p = mkpl(cr(2'd2), er(2'd0, 2'd3), er(2'd1, 2'd3));
            {4'd11, 2'd0}: p = mkpl(cr(2'd0), er(2'd2, 2'd1), er(2'd3, 2'd1));
            {4'd11, 2'd1}: p = mkpl(cr(2'd2), er(2'd3, 2'd1), er(2'd0, 2'd1));
            {4'd11, 2'd2}: p = mkpl(cr(2'd3), er(2'd0, 2'd1), er(2'd2, 2'd1));
            {4'd12, 2'd0}: p = mkpl(cr(2'd0), er(2'd3, 2'd2), er(2'd1, 2'd2));
            {4'd12, 2'd1}: p = mkpl(cr(2'd1), er(2'd0, 2'd2), er(2'd3, 2'd2));
            {4'd12, 2'd2}: p = mkpl(cr(2'd3), er(2'd1, 2'd2), er(2'd0, 2'd2));
            {4'd13, 2'd0}: p = mkpl(cr(2'd1), er(2'd3, 2'd0), er(2'd2, 2'd0));
            {4'd13, 2'd1}: p = mkpl(cr(2'd2), er(2'd1, 2'd0), er(2'd3, 2'd0));
            {4'd13, 2'd2}: p = mkpl(cr(2'd3), er(2'd2, 2'd0), er(2'd1, 2'd0));
            default:       p = mkpl(cr(2'd0), cr(2'd0), cr(2'd0));
        endcase
        return p;
    endfunction

    function automatic logic [1:0] last_plane(input logic [3:0] cand);
        logic [1:0] n;
        n = ((cand >= 4'd4) && (cand <= 4'd9)) ? 2'd1 : 2'd2;
        return n;
    endfunction

    function automatic logic [2:0] edge_of(input logic [1:0] f, input logic [1:0] t);
        logic [2:0] k;
        unique case ({f, t})
            {2'd0, 2'd1}, {2'd1, 2'd0}: k = 3'd0;
            {2'd0, 2'd2}, {2'd2, 2'd0}: k = 3'd1;
            {2'd0, 2'd3}, {2'd3, 2'd0}: k = 3'd2;
            {2'd1, 2'd2}, {2'd2, 2'd1}: k = 3'd3;
            {2'd1, 2'd3}, {2'd3, 2'd1}: k = 3'd4;
            {2'd2, 2'd3}, {2'd3, 2'd2}: k = 3'd5;
            default:                    k = 3'd0;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] kind_start(input logic [1:0] kind);
        logic [3:0] s;
        unique case (kind)
            KIND_VERTEX: s = 4'd0;
            KIND_EDGE:   s = 4'd4;
            KIND_FACE:   s = 4'd10;
            default:     s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] kind_end(input logic [1:0] kind);
        logic [3:0] e;
        unique case (kind)
            KIND_VERTEX: e = 4'd4;
            KIND_EDGE:   e = 4'd10;
            KIND_FACE:   e = 4'd14;
            default:     e = 4'd0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- sv/qpvt_dp.sv -----
// Datapath: point and fraction stores, edge point builder, shared multiplier, accumulators.
`default_nettype none

module qpvt_dp
    import qpvt_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                       clk,
    input  wire dp_cmd_t                    cmd,
    input  wire logic [2:0]                 slot,
    input  wire logic signed [COORD_BITS-1:0] x_coord,
    input  wire logic signed [COORD_BITS-1:0] y_coord,
    input  wire logic signed [COORD_BITS-1:0] z_coord,
    input  wire logic [FRACTION_BITS:0]     frac_from_low_end,
    input  wire logic [FRACTION_BITS:0]     frac_from_high_end,
    output logic                            positive
);

    localparam int C  = COORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int D  = C + 1;
    localparam int MW = (C + 2 > F + 2) ? C + 2 : F + 2;
    localparam int PW = 2 * MW;
    localparam int NW = 2 * D + 1;
    localparam int DW = 3 * D + 4;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (F - 1);

    logic signed [C-1:0] pt_mem [5][3];
    logic        [F:0]   fr_mem [6][2];

    logic signed [C-1:0] ea_reg [3];
    logic signed [D-1:0] ed_reg [3];
    logic        [F:0]   alpha_reg;
    logic signed [C-1:0] p_reg [3][3];
    logic signed [D-1:0] u_reg [3];
    logic signed [D-1:0] v_reg [3];
    logic signed [D-1:0] q_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic signed [NW-1:0] n_acc_reg;
    logic signed [NW-1:0] n_reg [3];
    logic signed [DW-1:0] d_acc_reg;

    logic signed [C-1:0]  pt_rd [3];
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [NW-1:0] n_sel;
    logic signed [D-1:0]  q_sel;
    logic signed [PW-1:0] rnd_sum;
    logic signed [PW-1:0] rnd_val;
    logic signed [DW-1:0] term;
    logic [F:0]           lo_sat;
    logic [F:0]           hi_sat;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pt_rd[c] = pt_mem[cmd.pt_addr][c];
        end
        lo_sat = (frac_from_low_end > ONE) ? ONE : frac_from_low_end;
        hi_sat = (frac_from_high_end > ONE) ? ONE : frac_from_high_end;
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        n_sel = n_reg[0];
        q_sel = q_reg[0];
        unique case (cmd.step)
            4'd6, 4'd7:   begin n_sel = n_reg[0]; q_sel = q_reg[0]; end
            4'd8, 4'd9:   begin n_sel = n_reg[1]; q_sel = q_reg[1]; end
            4'd10, 4'd11: begin n_sel = n_reg[2]; q_sel = q_reg[2]; end
            default:      begin n_sel = n_reg[0]; q_sel = q_reg[0]; end
        endcase

        mul_a = '0;
        mul_b = '0;
        if (cmd.op == DP_EDGE_MUL)
        begin
            mul_a = MW'(alpha_reg);
            mul_b = MW'(ed_reg[cmd.coord]);
        end
        else if (cmd.op == DP_MUL)
        begin
            unique case (cmd.step)
                4'd0:    begin mul_a = MW'(u_reg[1]); mul_b = MW'(v_reg[2]); end
                4'd1:    begin mul_a = MW'(u_reg[2]); mul_b = MW'(v_reg[1]); end
                4'd2:    begin mul_a = MW'(u_reg[2]); mul_b = MW'(v_reg[0]); end
                4'd3:    begin mul_a = MW'(u_reg[0]); mul_b = MW'(v_reg[2]); end
                4'd4:    begin mul_a = MW'(u_reg[0]); mul_b = MW'(v_reg[1]); end
                4'd5:    begin mul_a = MW'(u_reg[1]); mul_b = MW'(v_reg[0]); end
                default:
                begin
                    // split the normal: low part unsigned, high part signed
                    if (cmd.step[0])
                    begin
                        mul_a = MW'($signed(n_sel[NW-1:D]));
                    end
                    else
                    begin
                        mul_a = MW'({1'b0, n_sel[D-1:0]});
                    end
                    mul_b = MW'(q_sel);
                end
            endcase
        end
        mul_p = mul_a * mul_b;

        // round half up, then floor shift
        rnd_sum = prod_reg + HALF;
        rnd_val = rnd_sum >>> F;

        if (cmd.step[0])
        begin
            term = DW'(prod_reg) <<< D;
        end
        else
        begin
            term = DW'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_pt)
        begin
            pt_mem[slot][0] <= x_coord;
            pt_mem[slot][1] <= y_coord;
            pt_mem[slot][2] <= z_coord;
        end
        if (cmd.wr_fr)
        begin
            fr_mem[slot][0] <= lo_sat;
            fr_mem[slot][1] <= hi_sat;
        end

        unique case (cmd.op)
            DP_LD_CORNER:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p_reg[cmd.role][c] <= pt_rd[c];
                end
            end
            DP_EDGE_F:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ea_reg[c] <= pt_rd[c];
                end
                alpha_reg <= fr_mem[cmd.fr_addr][cmd.fr_hi];
            end
            DP_EDGE_T:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ed_reg[c] <= D'(pt_rd[c]) - D'(ea_reg[c]);
                end
            end
            DP_EDGE_MUL, DP_MUL:
            begin
                prod_reg <= mul_p;
            end
            DP_EDGE_ADD:
            begin
                p_reg[cmd.role][cmd.coord] <= ea_reg[cmd.coord] + C'(rnd_val);
            end
            DP_DIFF:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    u_reg[c] <= D'(p_reg[1][c]) - D'(p_reg[0][c]);
                    v_reg[c] <= D'(p_reg[2][c]) - D'(p_reg[0][c]);
                    q_reg[c] <= D'(pt_rd[c]) - D'(p_reg[0][c]);
                end
            end
            DP_ACC:
            begin
                if (cmd.step < STEP_DIST0)
                begin
                    if (cmd.step[0])
                    begin
                        n_reg[cmd.step[2:1]] <= n_acc_reg - NW'(prod_reg);
                    end
                    else
                    begin
                        n_acc_reg <= NW'(prod_reg);
                    end
                end
                else if (cmd.step == STEP_DIST0)
                begin
                    d_acc_reg <= term;
                end
                else
                begin
                    d_acc_reg <= d_acc_reg + term;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign positive = !d_acc_reg[DW-1] && (d_acc_reg != '0);

endmodule

`default_nettype wire

// ----- sv/qpvt_ctrl.sv -----
// Controller: request handshake, candidate/plane sequencing and result register.
`default_nettype none

module qpvt_ctrl
    import qpvt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [2:0] slot,
    input  wire logic [1:0] test_kind,
    input  wire logic       quad_present,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            violating,
    output logic [2:0]      nearest_index,
    output logic            skipped,
    input  wire logic       positive,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_EDGE_T,
        S_EMUL,
        S_EADD,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_TEST
    } state_t;

    state_t     state_reg;
    logic [3:0] cand_reg;
    logic [3:0] start_reg;
    logic [3:0] end_reg;
    logic [1:0] plane_reg;
    logic [1:0] role_reg;
    logic [1:0] coord_reg;
    logic [3:0] step_reg;
    logic       out_valid_reg;
    logic       violating_reg;
    logic [2:0] index_reg;
    logic       skipped_reg;

    plane_t     cur_plane;
    ref_t       cur_ref;
    logic       accept;
    logic [3:0] cand_off;

    always_comb
    begin
        cur_plane = cand_plane(cand_reg, plane_reg);
        cur_ref   = cur_plane[role_reg];
        in_ready  = (state_reg == S_IDLE) &&
                    !((op == OP_CHECK) && out_valid_reg && !out_ready);
        accept    = in_valid && in_ready;
        cand_off  = cand_reg - start_reg;

        cmd         = '0;
        cmd.op      = DP_NOP;
        cmd.wr_pt   = accept && (op == OP_LOAD_POINT) && (slot < NUM_POINTS);
        cmd.wr_fr   = accept && (op == OP_LOAD_FRAC) && (slot < NUM_EDGES);
        cmd.role    = role_reg;
        cmd.coord   = coord_reg;
        cmd.step    = step_reg;
        cmd.fr_addr = edge_of(cur_ref.f, cur_ref.t);
        cmd.fr_hi   = cur_ref.f > cur_ref.t;
        unique case (state_reg)
            S_FETCH:
            begin
                cmd.op      = cur_ref.is_edge ? DP_EDGE_F : DP_LD_CORNER;
                cmd.pt_addr = cur_ref.is_edge ? {1'b0, cur_ref.f} : {1'b0, cur_ref.t};
            end
            S_EDGE_T:
            begin
                cmd.op      = DP_EDGE_T;
                cmd.pt_addr = {1'b0, cur_ref.t};
            end
            S_EMUL:  cmd.op = DP_EDGE_MUL;
            S_EADD:  cmd.op = DP_EDGE_ADD;
            S_DIFF:
            begin
                cmd.op      = DP_DIFF;
                cmd.pt_addr = QUAD_SLOT;
            end
            S_MUL:   cmd.op = DP_MUL;
            S_ACC:   cmd.op = DP_ACC;
            default: cmd.op = DP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cand_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            plane_reg     <= '0;
            role_reg      <= '0;
            coord_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            violating_reg <= 1'b0;
            index_reg     <= '0;
            skipped_reg   <= 1'b0;
        end
        else
        begin
            // drop the result once taken; a new result below overrides
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (op == OP_CHECK))
                    begin
                        if (!quad_present)
                        begin
                            out_valid_reg <= 1'b1;
                            violating_reg <= 1'b0;
                            index_reg     <= '0;
                            skipped_reg   <= 1'b1;
                        end
                        else if (test_kind > KIND_FACE)
                        begin
                            out_valid_reg <= 1'b1;
                            violating_reg <= 1'b0;
                            index_reg     <= '0;
                            skipped_reg   <= 1'b0;
                        end
                        else
                        begin
                            cand_reg  <= kind_start(test_kind);
                            start_reg <= kind_start(test_kind);
                            end_reg   <= kind_end(test_kind);
                            plane_reg <= '0;
                            role_reg  <= '0;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_FETCH:
                begin
                    if (cur_ref.is_edge)
                    begin
                        state_reg <= S_EDGE_T;
                    end
                    else if (role_reg == LAST_ROLE)
                    begin
                        state_reg <= S_DIFF;
                    end
                    else
                    begin
                        role_reg <= role_reg + 2'd1;
                    end
                end
                S_EDGE_T:
                begin
                    coord_reg <= '0;
                    state_reg <= S_EMUL;
                end
                S_EMUL:
                begin
                    state_reg <= S_EADD;
                end
                S_EADD:
                begin
                    if (coord_reg == LAST_COORD)
                    begin
                        if (role_reg == LAST_ROLE)
                        begin
                            state_reg <= S_DIFF;
                        end
                        else
                        begin
                            role_reg  <= role_reg + 2'd1;
                            state_reg <= S_FETCH;
                        end
                    end
                    else
                    begin
                        coord_reg <= coord_reg + 2'd1;
                        state_reg <= S_EMUL;
                    end
                end
                S_DIFF:
                begin
                    step_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= S_TEST;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_TEST:
                begin
                    role_reg <= '0;
                    if (positive)
                    begin
                        if (plane_reg == last_plane(cand_reg))
                        begin
                            out_valid_reg <= 1'b1;
                            violating_reg <= 1'b1;
                            index_reg     <= cand_off[2:0];
                            skipped_reg   <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            plane_reg <= plane_reg + 2'd1;
                            state_reg <= S_FETCH;
                        end
                    end
                    else if (cand_reg + 4'd1 == end_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        violating_reg <= 1'b0;
                        index_reg     <= '0;
                        skipped_reg   <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        cand_reg  <= cand_reg + 4'd1;
                        plane_reg <= '0;
                        state_reg <= S_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign violating     = violating_reg;
    assign nearest_index = index_reg;
    assign skipped       = skipped_reg;

endmodule

`default_nettype wire

// ----- sv/quadruple_point_violation_test_unit.sv -----
// Top level: quadruple point violation test for one tetrahedron.
//
// Requests arrive on the in channel (in_valid/in_ready): op 0 loads a point
// (corners in slots 0..3, quadruple in slot 4), op 1 loads the two cut
// fractions of an edge, op 2 runs a vertex, edge or face check. Loads are
// written at accept and give no result. A check gives one result on the out
// channel (out_valid/out_ready): violating, nearest_index, skipped.
// An absent quadruple or unused test kind answers in the cycle after accept.
// Otherwise each plane tested costs 3 point fetches (a corner read directly,
// an edge cut point built through the shared multiplier one coordinate at a
// time), a difference step, the multiply and accumulate steps for the normal
// and the plane distance, and a test step; up to 12 planes a check.
// Loads are taken while a result waits; a new check waits until the result
// register is free. Reset empties the result register and returns the
// sequencer to idle; stored points and fractions are undefined until loaded.
`default_nettype none

module quadruple_point_violation_test_unit
    import qpvt_pkg::*;
#(
    parameter int COORD_BITS    = 24,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   op,
    input  wire logic [2:0]                   slot,
    input  wire logic signed [COORD_BITS-1:0] x_coord,
    input  wire logic signed [COORD_BITS-1:0] y_coord,
    input  wire logic signed [COORD_BITS-1:0] z_coord,
    input  wire logic [FRACTION_BITS:0]       frac_from_low_end,
    input  wire logic [FRACTION_BITS:0]       frac_from_high_end,
    input  wire logic [1:0]                   test_kind,
    input  wire logic                         quad_present,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              violating,
    output logic [2:0]                        nearest_index,
    output logic                              skipped
);

    dp_cmd_t cmd;
    logic    positive;

    qpvt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .slot          (slot),
        .test_kind     (test_kind),
        .quad_present  (quad_present),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .violating     (violating),
        .nearest_index (nearest_index),
        .skipped       (skipped),
        .positive      (positive),
        .cmd           (cmd)
    );

    qpvt_dp #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk                (clk),
        .cmd                (cmd),
        .slot               (slot),
        .x_coord            (x_coord),
        .y_coord            (y_coord),
        .z_coord            (z_coord),
        .frac_from_low_end  (frac_from_low_end),
        .frac_from_high_end (frac_from_high_end),
        .positive           (positive)
    );

endmodule

`default_nettype wire

// ----- verif/tb_quadruple_point_violation_test_unit.sv -----
// Testbench for the quadruple point violation test unit: directed and random tetrahedra, scoreboard checks.
`timescale 1ns / 1ps

module tb_quadruple_point_violation_test_unit;
    import qpvt_pkg::*;

    localparam int COORD_W = 24;
    localparam int FRAC_W = 16;
    localparam longint FRAC_ONE = 64'd1 << FRAC_W;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } vec_t;

    typedef struct {
        logic       violating;
        logic [2:0] nearest_index;
        logic       skipped;
    } verdict_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [1:0]                 op;
    logic [2:0]                 slot;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic signed [COORD_W-1:0]  z_coord;
    logic [FRAC_W:0]            frac_from_low_end;
    logic [FRAC_W:0]            frac_from_high_end;
    logic [1:0]                 test_kind;
    logic                       quad_present;
    logic                       out_valid;
    logic                       out_ready;
    logic                       violating;
    logic [2:0]                 nearest_index;
    logic                       skipped;

    // Plane refs: 0..3 corners, 4 + 4*f + t the cut point on edge f->t
    int plane_ref [14][3][3] = '{
        '{'{5, 2, 3}, '{6, 3, 1}, '{7, 1, 2}},
        '{'{8, 3, 2}, '{11, 2, 0}, '{10, 0, 3}},
        '{'{12, 1, 3}, '{15, 0, 1}, '{13, 3, 0}},
        '{'{16, 2, 1}, '{18, 1, 0}, '{17, 0, 2}},
        '{'{1, 6, 7}, '{0, 11, 10}, '{0, 0, 0}},
        '{'{2, 7, 5}, '{0, 13, 15}, '{0, 0, 0}},
        '{'{3, 5, 6}, '{0, 18, 17}, '{0, 0, 0}},
        '{'{2, 8, 11}, '{1, 15, 12}, '{0, 0, 0}},
        '{'{3, 10, 8}, '{1, 16, 18}, '{0, 0, 0}},
        '{'{3, 12, 13}, '{2, 17, 16}, '{0, 0, 0}},
        '{'{0, 11, 15}, '{1, 15, 7}, '{2, 7, 11}},
        '{'{0, 13, 17}, '{2, 17, 5}, '{3, 5, 13}},
        '{'{0, 18, 10}, '{1, 6, 18}, '{3, 10, 6}},
        '{'{1, 16, 12}, '{2, 8, 16}, '{3, 12, 8}}
    };

    vec_t     points [5];
    longint   cut_frac [6][2];
    verdict_t expected_verdicts [$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       requests_sent = 0;
    int       cycles = 0;

    quadruple_point_violation_test_unit dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .op                 (op),
        .slot               (slot),
        .x_coord            (x_coord),
        .y_coord            (y_coord),
        .z_coord            (z_coord),
        .frac_from_low_end  (frac_from_low_end),
        .frac_from_high_end (frac_from_high_end),
        .test_kind          (test_kind),
        .quad_present       (quad_present),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .violating          (violating),
        .nearest_index      (nearest_index),
        .skipped            (skipped)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int edge_index(int f, int t);
        int lo;
        int hi;
        lo = (f < t) ? f : t;
        hi = (f < t) ? t : f;
        if (lo == 0)
            return hi - 1;
        if (lo == 1)
            return hi + 1;
        return 5;
    endfunction

    function automatic longint cut_offset(longint alpha, longint d);
        longint prod;
        prod = alpha * d + (FRAC_ONE >> 1);
        return prod >>> FRAC_W;
    endfunction

    function automatic vec_t locate_point(int r);
        vec_t a;
        vec_t b;
        vec_t p;
        int f;
        int t;
        longint alpha;
        if (r < 4)
            return points[r];
        f = (r - 4) >> 2;
        t = (r - 4) & 3;
        alpha = cut_frac[edge_index(f, t)][(f < t) ? 0 : 1];
        a = points[f];
        b = points[t];
        p.x = a.x + cut_offset(alpha, b.x - a.x);
        p.y = a.y + cut_offset(alpha, b.y - a.y);
        p.z = a.z + cut_offset(alpha, b.z - a.z);
        return p;
    endfunction

    function automatic bit quad_above_plane(int c, int pl);
        vec_t b;
        vec_t pa;
        vec_t pb;
        logic signed [127:0] ux, uy, uz, vx, vy, vz, qx, qy, qz;
        logic signed [127:0] nx, ny, nz, plane_dist;
        b = locate_point(plane_ref[c][pl][0]);
        pa = locate_point(plane_ref[c][pl][1]);
        pb = locate_point(plane_ref[c][pl][2]);
        ux = pa.x - b.x;
        uy = pa.y - b.y;
        uz = pa.z - b.z;
        vx = pb.x - b.x;
        vy = pb.y - b.y;
        vz = pb.z - b.z;
        qx = points[4].x - b.x;
        qy = points[4].y - b.y;
        qz = points[4].z - b.z;
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        plane_dist = nx * qx + ny * qy + nz * qz;
        return plane_dist > 0;
    endfunction

    function automatic verdict_t predict_verdict(logic [1:0] kind, logic present);
        verdict_t v;
        int first;
        int count;
        int planes;
        bit all_pos;
        v.violating = 1'b0;
        v.nearest_index = 3'd0;
        v.skipped = 1'b0;
        if (!present)
        begin
            v.skipped = 1'b1;
            return v;
        end
        case (kind)
            KIND_VERTEX:
            begin
                first = 0;
                count = 4;
            end
            KIND_EDGE:
            begin
                first = 4;
                count = 6;
            end
            KIND_FACE:
            begin
                first = 10;
                count = 4;
            end
            default:
                return v;
        endcase
        for (int c = 0; c < count; c++)
        begin
            planes = (first + c >= 4 && first + c <= 9) ? 2 : 3;
            all_pos = 1'b1;
            for (int p = 0; p < planes && all_pos; p++)
                all_pos = quad_above_plane(first + c, p);
            if (all_pos)
            begin
                v.violating = 1'b1;
                v.nearest_index = c[2:0];
                return v;
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // Apply one accepted request to the local copy of the stores, or queue the predicted verdict of a check
    task automatic apply_request(logic [1:0] o, logic [2:0] s, longint x, longint y, longint z,
                                 longint flo, longint fhi, logic [1:0] kind, logic present);
        if (o == OP_LOAD_POINT && s < NUM_POINTS)
        begin
            points[s].x = x;
            points[s].y = y;
            points[s].z = z;
        end
        else if (o == OP_LOAD_FRAC && s < NUM_EDGES)
        begin
            cut_frac[s][0] = (flo > FRAC_ONE) ? FRAC_ONE : flo;
            cut_frac[s][1] = (fhi > FRAC_ONE) ? FRAC_ONE : fhi;
        end
        else if (o == OP_CHECK)
            expected_verdicts.push_back(predict_verdict(kind, present));
    endtask

    task automatic send_request(logic [1:0] o, logic [2:0] s, longint x, longint y, longint z,
                                longint flo, longint fhi, logic [1:0] kind, logic present);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        slot <= s;
        x_coord <= x[COORD_W-1:0];
        y_coord <= y[COORD_W-1:0];
        z_coord <= z[COORD_W-1:0];
        frac_from_low_end <= flo[FRAC_W:0];
        frac_from_high_end <= fhi[FRAC_W:0];
        test_kind <= kind;
        quad_present <= present;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        apply_request(o, s, x, y, z, flo, fhi, kind, present);
        requests_sent++;
    endtask

    function automatic longint rand_coord();
        return longint'($signed($urandom_range(32'h00FF_FFFF, 0) << 8)) >>> 8;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    task automatic load_point(int s, longint x, longint y, longint z);
        send_request(OP_LOAD_POINT, s[2:0], x, y, z, $urandom_range(131071),
                     $urandom_range(131071), 2'($urandom_range(3)),
                     1'($urandom_range(1)));
    endtask

    task automatic load_frac(int s, longint flo, longint fhi);
        send_request(OP_LOAD_FRAC, s[2:0], rand_coord(), rand_coord(), rand_coord(),
                     flo, fhi, 2'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    task automatic run_check(logic [1:0] kind, logic present);
        send_request(OP_CHECK, 3'($urandom_range(7)), rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(131071), $urandom_range(131071), kind, present);
    endtask

    // Hold off the sender until every pending verdict has come back
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        load_point(0, COORD_MAX, COORD_MAX, COORD_MAX);
        load_point(1, COORD_MIN, COORD_MAX, COORD_MIN);
        load_point(2, COORD_MIN, COORD_MIN, COORD_MAX);
        load_point(3, COORD_MAX, COORD_MIN, COORD_MIN);
        load_point(4, COORD_MAX - 4096, COORD_MAX - 8192, COORD_MAX - 4096);
        load_frac(0, 0, FRAC_ONE);
        load_frac(1, FRAC_ONE, 0);
        load_frac(2, 131071, 65537);
        load_frac(3, 16384, 16384);
        load_frac(4, 32768, 49152);
        load_frac(5, 1, 65535);
        // out-of-range slots and the unused op must leave the stores alone
        load_point(5, 0, 0, 0);
        load_point(7, 1, 1, 1);
        load_frac(6, 0, 0);
        load_frac(7, 0, 0);
        send_request(OP_UNUSED, 3'd0, 0, 0, 0, 0, 0, KIND_VERTEX, 1'b1);
        run_check(KIND_VERTEX, 1'b1);
        run_check(KIND_EDGE, 1'b1);
        run_check(KIND_FACE, 1'b1);
        run_check(KIND_UNUSED, 1'b1);
        run_check(KIND_FACE, 1'b0);
        load_point(4, 0, 0, 0);
        run_check(KIND_VERTEX, 1'b1);
        run_check(KIND_EDGE, 1'b1);
        run_check(KIND_FACE, 1'b1);
    endtask

    task automatic load_random_tetra();
        longint span;
        vec_t c [4];
        vec_t q;
        int pick;
        span = ($urandom_range(9) == 0) ? COORD_MAX : longint'($urandom_range(1 << 20, 64));
        for (int i = 0; i < 4; i++)
        begin
            c[i].x = (span == COORD_MAX) ? rand_coord() : $signed($urandom_range(2 * span)) - span;
            c[i].y = (span == COORD_MAX) ? rand_coord() : $signed($urandom_range(2 * span)) - span;
            c[i].z = (span == COORD_MAX) ? rand_coord() : $signed($urandom_range(2 * span)) - span;
            load_point(i, c[i].x, c[i].y, c[i].z);
        end
        pick = $urandom_range(5);
        if (pick < 4)
        begin
            q.x = clamp_coord(c[pick].x + ($signed($urandom_range(2 * span)) - span) / 4);
            q.y = clamp_coord(c[pick].y + ($signed($urandom_range(2 * span)) - span) / 4);
            q.z = clamp_coord(c[pick].z + ($signed($urandom_range(2 * span)) - span) / 4);
        end
        else
        begin
            q.x = (c[0].x + c[1].x + c[2].x + c[3].x) / 4;
            q.y = (c[0].y + c[1].y + c[2].y + c[3].y) / 4;
            q.z = (c[0].z + c[1].z + c[2].z + c[3].z) / 4;
        end
        load_point(4, q.x, q.y, q.z);
        for (int e = 0; e < 6; e++)
        begin
            if ($urandom_range(15) == 0)
                load_frac(e, $urandom_range(131071), $urandom_range(131071));
            else
                load_frac(e, $urandom_range(65536), $urandom_range(65536));
        end
    endtask

    task automatic random_noise();
        case ($urandom_range(3))
            0: load_point($urandom_range(7, 5), rand_coord(), rand_coord(), rand_coord());
            1: load_frac($urandom_range(7, 6), $urandom_range(131071), $urandom_range(131071));
            2: send_request(OP_UNUSED, 3'($urandom_range(7)), rand_coord(), rand_coord(),
                            rand_coord(), $urandom_range(131071), $urandom_range(131071),
                            2'($urandom_range(3)), 1'($urandom_range(1)));
            default: load_point(4, rand_coord(), rand_coord(), rand_coord());
        endcase
    endtask

    task automatic test_random(int budget, bit with_pause);
        int stop_at;
        int pause_at;
        logic [1:0] kind;
        stop_at = requests_sent + budget;
        pause_at = requests_sent + budget / 2;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(4) == 0)
                random_noise();
            else
                load_random_tetra();
            repeat ($urandom_range(4, 1))
            begin
                kind = ($urandom_range(19) == 0) ? KIND_UNUSED : 2'($urandom_range(2));
                run_check(kind, $urandom_range(9) != 0);
            end
            if (with_pause && requests_sent >= pause_at)
            begin
                drain_verdicts();
                with_pause = 1'b0;
            end
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("result with no pending check");
            else
            begin
                exp_v = expected_verdicts.pop_front();
                if (violating !== exp_v.violating)
                    report_mismatch($sformatf("violating %0b, want %0b",
                                              violating, exp_v.violating));
                if (nearest_index !== exp_v.nearest_index)
                    report_mismatch($sformatf("nearest_index %0d, want %0d",
                                              nearest_index, exp_v.nearest_index));
                if (skipped !== exp_v.skipped)
                    report_mismatch($sformatf("skipped %0b, want %0b",
                                              skipped, exp_v.skipped));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_quadruple_point_violation_test_unit failed");
            $finish;
        end
    end

    initial
    begin
        int tail;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= OP_LOAD_POINT;
        slot <= 3'd0;
        x_coord <= '0;
        y_coord <= '0;
        z_coord <= '0;
        frac_from_low_end <= '0;
        frac_from_high_end <= '0;
        test_kind <= KIND_VERTEX;
        quad_present <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 23;
        recv_idle_pct = 62;
        test_random(500, 1'b0);
        send_idle_pct = 62;
        recv_idle_pct = 23;
        test_random(500, 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 50)
        begin
            @(posedge clk);
            tail++;
        end
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("tb_quadruple_point_violation_test_unit passed");
        else
            $display("tb_quadruple_point_violation_test_unit failed");
        $finish;
    end

endmodule
